[rtl/qapm_pkg.sv]
`default_nettype none
package qapm_pkg;

    localparam int CFG_NUM    = 8;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_SLOT_W = 3;

    localparam logic [CFG_SLOT_W-1:0] CFG_PITCH_P   = 3'd0;
    localparam logic [CFG_SLOT_W-1:0] CFG_PITCH_D   = 3'd1;
    localparam logic [CFG_SLOT_W-1:0] CFG_PITCH_I   = 3'd2;
    localparam logic [CFG_SLOT_W-1:0] CFG_ROLL_P    = 3'd3;
    localparam logic [CFG_SLOT_W-1:0] CFG_ROLL_D    = 3'd4;
    localparam logic [CFG_SLOT_W-1:0] CFG_ROLL_I    = 3'd5;
    localparam logic [CFG_SLOT_W-1:0] CFG_YAW_P     = 3'd6;
    localparam logic [CFG_SLOT_W-1:0] CFG_INT_LIMIT = 3'd7;

    localparam int IN_TDATA_W  = 152;
    localparam int OUT_TDATA_W = 48;
    localparam int DRIVE_W     = 11;

    typedef logic [15:0] t_gain;
    typedef logic [DRIVE_W-1:0] t_drive;

    localparam t_drive IDLE_DRIVE = 11'd2;

    // k*C/127 split as k*Q + round(k*R/127)
    localparam logic [16:0] SP_ANG_Q  = 17'd16;
    localparam logic [6:0]  SP_ANG_R  = 7'd16;
    localparam logic [16:0] SP_YAW_Q  = 17'd141;
    localparam logic [6:0]  SP_YAW_R  = 7'd13;
    localparam logic [16:0] THR_Q     = 17'd129007;
    localparam logic [6:0]  THR_R     = 7'd111;
    localparam logic [33:0] RECIP_127 = 34'd16514;
    localparam logic signed [27:0] THRUST_BASE = 28'sd95027200;
    localparam logic signed [24:0] DEADBAND    = 25'sd256;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SP,
        ST_ERR,
        ST_MAC,
        ST_INT,
        ST_MIX
    } t_state;

    typedef enum logic [2:0] {
        TERM_PITCH_I,
        TERM_ROLL_I,
        TERM_PITCH_P,
        TERM_PITCH_D,
        TERM_ROLL_P,
        TERM_ROLL_D,
        TERM_YAW_P
    } t_term;

    localparam logic [2:0] TERM_COUNT = 3'd7;

    typedef struct packed {
        logic  load_in;
        logic  calc_sp;
        logic  calc_err;
        logic  mul_en;
        t_term mul_sel;
        logic  acc_en;
        t_term acc_sel;
        logic  add_int;
        logic  load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic run;
        logic out_free;
    } t_dp_status;

    function automatic t_gain cfg_reset_val(input logic [CFG_SLOT_W-1:0] slot);
        t_gain v;
        case (slot)
            CFG_PITCH_P:   v = 16'd2560;
            CFG_PITCH_D:   v = 16'd512;
            CFG_PITCH_I:   v = 16'd26;
            CFG_ROLL_P:    v = 16'd3072;
            CFG_ROLL_D:    v = 16'd640;
            CFG_ROLL_I:    v = 16'd26;
            CFG_YAW_P:     v = 16'd1408;
            CFG_INT_LIMIT: v = 16'd25600;
            default:       v = 16'd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

[rtl/qapm_ctrl.sv]
`default_nettype none
module qapm_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    output qapm_pkg::t_dp_cmd    o_cmd,
    input  qapm_pkg::t_dp_status i_status
);
    import qapm_pkg::*;

    t_state     r_state, n_state;
    logic [2:0] r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= 3'd0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = ST_SP;
                end
            end
            ST_SP: begin
                o_cmd.calc_sp = 1'b1;
                n_state       = i_status.run ? ST_ERR : ST_MIX;
            end
            ST_ERR: begin
                o_cmd.calc_err = 1'b1;
                n_cnt          = 3'd0;
                n_state        = ST_MAC;
            end
            ST_MAC: begin
                if (r_cnt != TERM_COUNT) begin
                    o_cmd.mul_en  = 1'b1;
                    o_cmd.mul_sel = t_term'(r_cnt);
                end
                if (r_cnt != 3'd0) begin
                    o_cmd.acc_en  = 1'b1;
                    o_cmd.acc_sel = t_term'(r_cnt - 3'd1);
                end
                if (r_cnt == TERM_COUNT) begin
                    n_state = ST_INT;
                end else begin
                    n_cnt = r_cnt + 3'd1;
                end
            end
            ST_INT: begin
                o_cmd.add_int = 1'b1;
                n_state       = ST_MIX;
            end
            ST_MIX: begin
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

[rtl/qapm_dp.sv]
`default_nettype none
module qapm_dp #(
    parameter int DRIVE_MAX = 2000
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  qapm_pkg::t_dp_cmd                    i_cmd,
    output qapm_pkg::t_dp_status                 o_status,
    input  logic [qapm_pkg::IN_TDATA_W-1:0]      i_in_data,
    input  logic                                 i_in_run,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output qapm_pkg::t_drive                     o_drive_a,
    output qapm_pkg::t_drive                     o_drive_b,
    output qapm_pkg::t_drive                     o_drive_c,
    output qapm_pkg::t_drive                     o_drive_d,
    input  logic                                 i_cfg_valid,
    input  logic [qapm_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [15:0]                          i_cfg_data
);
    import qapm_pkg::*;

    localparam logic [31:0] DRV_LIMIT = 32'(DRIVE_MAX);

    t_gain r_cfg [CFG_NUM];

    logic [7:0]         r_stick_pitch, r_stick_roll, r_stick_yaw, r_stick_thrust;
    logic signed [23:0] r_pitch_ang, r_roll_ang, r_rate_x, r_rate_y, r_rate_z;
    logic               r_run;

    logic signed [24:0] r_sp_p, r_sp_r, r_sp_y;
    logic signed [27:0] r_thr;
    logic signed [24:0] r_ep, r_er, r_ey;
    logic signed [41:0] r_prod;
    logic signed [23:0] r_pint, r_rint;
    logic signed [47:0] r_tp, r_tr, r_ty;
    logic               r_out_valid;
    t_drive             r_drive_a, r_drive_b, r_drive_c, r_drive_d;

    logic signed [8:0]  kp, kr, ky, kt;
    logic signed [24:0] ep_raw;
    t_gain              mul_gain;
    logic signed [24:0] mul_op;
    logic signed [41:0] mul_full;
    logic [23:0]        lim_full;
    logic signed [23:0] lim;
    logic signed [23:0] int_sel;
    logic signed [42:0] int_sum, int_next;
    logic signed [47:0] thr48, c0, c1, c2, c3;

    function automatic logic signed [27:0] sp_term(input logic signed [8:0] k,
                                                   input logic [16:0] qc,
                                                   input logic [6:0] rc);
        logic signed [27:0] base;
        logic signed [16:0] y;
        logic [15:0]        mag;
        logic [16:0]        t;
        logic [33:0]        p;
        logic [27:0]        q;
        base = 28'(k * $signed({1'b0, qc}));
        y    = 17'(k * $signed({1'b0, rc}));
        mag  = y[16] ? 16'(-y) : y[15:0];
        t    = {1'b0, mag} + 17'd63;
        p    = 34'(t) * RECIP_127;
        q    = 28'(p[28:21]);
        return y[16] ? base - $signed(q) : base + $signed(q);
    endfunction

    function automatic t_drive drive_of(input logic signed [47:0] c);
        logic [31:0] d;
        d = c[47:16];
        if (c[47]) begin
            return '0;
        end else if (d > DRV_LIMIT) begin
            return DRV_LIMIT[DRIVE_W-1:0];
        end else begin
            return d[DRIVE_W-1:0];
        end
    endfunction

    assign kp = 9'($signed({1'b0, r_stick_pitch}) - 9'sd128);
    assign kr = 9'($signed({1'b0, r_stick_roll}) - 9'sd128);
    assign ky = 9'($signed({1'b0, r_stick_yaw}) - 9'sd128);
    assign kt = 9'($signed({1'b0, r_stick_thrust}) - 9'sd128);

    assign ep_raw = r_sp_p - 25'(r_pitch_ang);

    always_comb begin
        case (i_cmd.mul_sel)
            TERM_PITCH_I: begin
                mul_gain = r_cfg[CFG_PITCH_I];
                mul_op   = r_ep;
            end
            TERM_ROLL_I: begin
                mul_gain = r_cfg[CFG_ROLL_I];
                mul_op   = r_er;
            end
            TERM_PITCH_P: begin
                mul_gain = r_cfg[CFG_PITCH_P];
                mul_op   = r_ep;
            end
            TERM_PITCH_D: begin
                mul_gain = r_cfg[CFG_PITCH_D];
                mul_op   = 25'(r_rate_z);
            end
            TERM_ROLL_P: begin
                mul_gain = r_cfg[CFG_ROLL_P];
                mul_op   = r_er;
            end
            TERM_ROLL_D: begin
                mul_gain = r_cfg[CFG_ROLL_D];
                mul_op   = 25'(r_rate_y);
            end
            TERM_YAW_P: begin
                mul_gain = r_cfg[CFG_YAW_P];
                mul_op   = r_ey;
            end
            default: begin
                mul_gain = '0;
                mul_op   = '0;
            end
        endcase
    end

    assign mul_full = 42'($signed({1'b0, mul_gain})) * 42'(mul_op);

    // integrator clamp
    assign lim_full = {r_cfg[CFG_INT_LIMIT], 8'h00};
    assign lim      = lim_full[23] ? 24'sh7FFFFF : $signed(lim_full);
    assign int_sel  = (i_cmd.acc_sel == TERM_PITCH_I) ? r_pint : r_rint;
    assign int_sum  = 43'(int_sel) + 43'(r_prod);

    always_comb begin
        if (int_sum > 43'(lim)) begin
            int_next = 43'(lim);
        end else if (int_sum < -43'(lim)) begin
            int_next = -43'(lim);
        end else begin
            int_next = int_sum;
        end
    end

    // mixer
    assign thr48 = 48'(r_thr);
    assign c0 = thr48 + r_tp + r_tr - r_ty;
    assign c1 = thr48 - r_tp + r_tr + r_ty;
    assign c2 = thr48 + r_tp - r_tr + r_ty;
    assign c3 = thr48 - r_tp - r_tr - r_ty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CFG_NUM; i++) begin
                r_cfg[i] <= cfg_reset_val(CFG_SLOT_W'(i));
            end
            r_pint      <= '0;
            r_rint      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && (i_cfg_index < CFG_IDX_W'(CFG_NUM))) begin
                r_cfg[i_cfg_index[CFG_SLOT_W-1:0]] <= i_cfg_data;
            end
            if (i_cmd.acc_en && (i_cmd.acc_sel == TERM_PITCH_I)) begin
                r_pint <= 24'(int_next);
            end
            if (i_cmd.acc_en && (i_cmd.acc_sel == TERM_ROLL_I)) begin
                r_rint <= 24'(int_next);
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_stick_pitch  <= i_in_data[7:0];
            r_stick_roll   <= i_in_data[15:8];
            r_stick_yaw    <= i_in_data[23:16];
            r_stick_thrust <= i_in_data[31:24];
            r_pitch_ang    <= $signed(i_in_data[55:32]);
            r_roll_ang     <= $signed(i_in_data[79:56]);
            r_rate_x       <= $signed(i_in_data[103:80]);
            r_rate_y       <= $signed(i_in_data[127:104]);
            r_rate_z       <= $signed(i_in_data[151:128]);
            r_run          <= i_in_run;
        end
        if (i_cmd.calc_sp) begin
            r_sp_p <= 25'(sp_term(kp, SP_ANG_Q, SP_ANG_R));
            r_sp_r <= 25'(sp_term(kr, SP_ANG_Q, SP_ANG_R));
            r_sp_y <= 25'(-sp_term(ky, SP_YAW_Q, SP_YAW_R));
            r_thr  <= THRUST_BASE - sp_term(kt, THR_Q, THR_R);
        end
        if (i_cmd.calc_err) begin
            r_ep <= ((ep_raw <= DEADBAND) && (ep_raw >= -DEADBAND)) ? '0 : ep_raw;
            r_er <= r_sp_r - 25'(r_roll_ang);
            r_ey <= r_sp_y - 25'(r_rate_x);
        end
        if (i_cmd.mul_en) begin
            r_prod <= mul_full;
        end
        if (i_cmd.acc_en) begin
            case (i_cmd.acc_sel)
                TERM_PITCH_P: r_tp <= 48'(r_prod);
                TERM_PITCH_D: r_tp <= r_tp - 48'(r_prod);
                TERM_ROLL_P:  r_tr <= 48'(r_prod);
                TERM_ROLL_D:  r_tr <= r_tr - 48'(r_prod);
                TERM_YAW_P:   r_ty <= 48'(r_prod);
                default: begin
                end
            endcase
        end
        if (i_cmd.add_int) begin
            r_tp <= r_tp + 48'(r_pint);
            r_tr <= r_tr + 48'(r_rint);
        end
        if (i_cmd.load_out) begin
            r_drive_a <= r_run ? drive_of(c0) : IDLE_DRIVE;
            r_drive_b <= r_run ? drive_of(c1) : IDLE_DRIVE;
            r_drive_c <= r_run ? drive_of(c2) : IDLE_DRIVE;
            r_drive_d <= r_run ? drive_of(c3) : IDLE_DRIVE;
        end
    end

    assign o_status.run      = r_run;
    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_drive_a         = r_drive_a;
    assign o_drive_b         = r_drive_b;
    assign o_drive_c         = r_drive_c;
    assign o_drive_d         = r_drive_d;

endmodule
`default_nettype wire

[rtl/quad_attitude_pid_mixer.sv]
// a running word passes the setpoint, error, multiply, integrator and mix states,
// a paused word only setpoint and mix; a new word is accepted only after the last
// one is mixed; the single multiplier takes the seven gain products one per cycle
// reset: synchronous active low, restores the gain registers and clears both integrators
// the result register holds a word until taken while the next word is being worked on
`default_nettype none
module quad_attitude_pid_mixer #(
    parameter int DRIVE_MAX = 2000
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // stick_pitch, stick_roll, stick_yaw, stick_thrust, pitch_ang, roll_ang,
    // rate_x, rate_y, rate_z
    input  logic [qapm_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // run_enable
    input  logic                                 s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // drive_a, drive_b, drive_c, drive_d, zero pad
    output logic [qapm_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [qapm_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [15:0]                          i_cfg_data
);
    import qapm_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;
    t_drive     drive_a, drive_b, drive_c, drive_d;

    qapm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .o_cmd      (cmd),
        .i_status   (status)
    );

    qapm_dp #(
        .DRIVE_MAX (DRIVE_MAX)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_in_data   (s_axis_tdata),
        .i_in_run    (s_axis_tuser),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_drive_a   (drive_a),
        .o_drive_b   (drive_b),
        .o_drive_c   (drive_c),
        .o_drive_d   (drive_d),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    assign o_cfg_ready  = 1'b1;
    assign m_axis_tdata = {4'b0000, drive_d, drive_c, drive_b, drive_a};

endmodule
`default_nettype wire
